>>> src/ttc_pkg.sv
// Shared types and field widths for the tile tag cache.
`timescale 1ns / 1ps

package ttc_pkg;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_LOOKUP   = 2'd0,
    OP_INSERT   = 2'd1,
    OP_ANCESTOR = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  localparam int ZOOM_W  = 5;
  localparam int COORD_W = 19;
  localparam int STAMP_W = 32;
  localparam int SLOT_W  = 4;
  localparam int LEVEL_W = 3;
  localparam int SUB_W   = 8;
  localparam int IN_W    = 48;
  localparam int OUT_W   = 32;

  // Tag of one tile: zoom level, column and row.
  typedef struct packed {
    logic [ZOOM_W-1:0]  zoom;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } tag_t;

endpackage

>>> src/tile_tag_cache_lru.sv
// Fully associative LRU tag store for map tiles, scanned by one shared compare unit.
`timescale 1ns / 1ps

// Channel  Dir  Width  Contents
// s_*      in   48     tdata: op[1:0], zoom[6:2], tile_x[25:7], tile_y[44:26], zeros above
// m_*      out  32     tdata: hit[0], slot[4:1], evicted[5], level[8:6], sub_x[16:9],
//                      sub_y[24:17], zeros above
//
// Each request is handled by a small sequencer that reads one cache entry per cycle from
// the tag and stamp memories and feeds it to a single tag comparator and stamp comparator.
// A lookup or insert makes one pass over the entries from the input transfer to the result
// being offered, less when a matching entry ends the scan early; an ancestor search makes
// up to MAX_LEVELS + 1 passes, one full pass over the entries for each coarser level
// tried. The next request can be accepted in the same cycle as the result is offered.
// s_tready is high only while the sequencer is idle; a finished result waits in the output
// register, so the next request can be accepted before it is taken.
// rst is synchronous and clears the valid bits, the stamp clock and the control state;
// tag and stamp memory contents are left as they are and are only read for valid entries.

module tile_tag_cache_lru #(
  parameter int ENTRIES     = 16,
  parameter int MAX_LEVELS  = 6,
  parameter int TILE_PIXELS = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // op, zoom, tile_x, tile_y from the lowest bit up
  input  logic [ttc_pkg::IN_W-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // hit, slot, evicted, level, sub_x, sub_y from the lowest bit up
  output logic [ttc_pkg::OUT_W-1:0] m_tdata
);

  localparam int IW  = $clog2(ENTRIES);
  localparam int TPW = $clog2(TILE_PIXELS + 1);
  localparam int MW  = 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state;

  // Entry storage: tags and stamps in memories, valid bits in flip-flops.
  ttc_pkg::tag_t                  tag_mem   [ENTRIES];
  logic [ttc_pkg::STAMP_W-1:0]    stamp_mem [ENTRIES];
  logic [ENTRIES-1:0]             valid;
  ttc_pkg::tag_t                  tag_q;
  logic [ttc_pkg::STAMP_W-1:0]    stamp_q;
  logic [ttc_pkg::STAMP_W-1:0]    stamp_clock;

  // Request context.
  ttc_pkg::op_t                   op_r;
  ttc_pkg::tag_t                  search;
  logic [ttc_pkg::COORD_W-1:0]    x_lat;
  logic [ttc_pkg::COORD_W-1:0]    y_lat;
  logic [ttc_pkg::LEVEL_W-1:0]    lvl;

  // Scan position: idx is the address being read, p_idx the entry now at the comparators.
  logic [IW:0]                    idx;
  logic [IW-1:0]                  p_idx;
  logic                           pv;

  // Replacement tracking over the scan.
  logic                           have_inv;
  logic [IW-1:0]                  inv_slot;
  logic [IW-1:0]                  min_slot;
  logic [ttc_pkg::STAMP_W-1:0]    min_val;

  // Result held until the output register is free.
  logic                           res_hit;
  logic [ttc_pkg::SLOT_W-1:0]     res_slot;
  logic                           res_evicted;
  logic [ttc_pkg::LEVEL_W-1:0]    res_level;
  logic [ttc_pkg::SUB_W-1:0]      res_sub_x;
  logic [ttc_pkg::SUB_W-1:0]      res_sub_y;

  // Combinational scan logic.
  logic                           issue;
  logic [IW-1:0]                  rd_addr;
  logic                           hit_now;
  logic                           end_now;
  logic                           have_inv_next;
  logic [IW-1:0]                  inv_slot_next;
  logic [IW-1:0]                  min_slot_next;
  logic [ttc_pkg::STAMP_W-1:0]    min_val_next;
  logic [IW-1:0]                  victim;
  logic                           ins_write;
  logic                           stamp_we;
  logic                           tag_we;
  logic [IW-1:0]                  wr_addr;
  logic [ttc_pkg::STAMP_W-1:0]    stamp_new;
  logic                           more_levels;
  logic [MW-1:0]                  lvl_mask;
  logic [MW-1:0]                  mx;
  logic [MW-1:0]                  my;
  logic [TPW-1:0]                 sub_step;
  logic [MW+TPW-1:0]              prod_x;
  logic [MW+TPW-1:0]              prod_y;

  assign s_tready  = (state == ST_IDLE);
  assign issue     = (state == ST_SCAN) && (idx != (IW+1)'(ENTRIES));
  assign rd_addr   = idx[IW-1:0];
  assign stamp_new = stamp_clock + 1'b1;

  always_comb begin
    hit_now = pv && valid[p_idx] && (tag_q == search);
    end_now = pv && (p_idx == IW'(ENTRIES - 1)) && !hit_now;

    // Fold the entry now at the comparators into the victim choice: the first invalid
    // slot wins, otherwise the least stamp with the lowest slot on ties.
    have_inv_next = have_inv;
    inv_slot_next = inv_slot;
    min_slot_next = min_slot;
    min_val_next  = min_val;
    if (pv && !have_inv) begin
      if (!valid[p_idx]) begin
        have_inv_next = 1'b1;
        inv_slot_next = p_idx;
      end else if (stamp_q < min_val) begin
        min_val_next  = stamp_q;
        min_slot_next = p_idx;
      end
    end
    victim = have_inv_next ? inv_slot_next : min_slot_next;

    ins_write = (state == ST_SCAN) && end_now && (op_r == ttc_pkg::OP_INSERT);
    stamp_we  = ((state == ST_SCAN) && hit_now) || ins_write;
    tag_we    = ins_write;
    wr_addr   = hit_now ? p_idx : victim;

    more_levels = (op_r == ttc_pkg::OP_ANCESTOR) && (search.zoom != '0) &&
                  ({1'b0, lvl} < (ttc_pkg::LEVEL_W+1)'(MAX_LEVELS));

    // Sub-tile offset: (coordinate mod 2^level) * (TILE_PIXELS >> level).
    lvl_mask = (MW'(1) << lvl) - MW'(1);
    mx       = MW'(x_lat) & lvl_mask;
    my       = MW'(y_lat) & lvl_mask;
    sub_step = TPW'(TILE_PIXELS) >> lvl;
    prod_x   = (MW+TPW)'(mx) * (MW+TPW)'(sub_step);
    prod_y   = (MW+TPW)'(my) * (MW+TPW)'(sub_step);
  end

  // Tag and stamp memories: one read and one write port each, read data registered.
  always_ff @(posedge clk) begin
    if (issue) begin
      tag_q   <= tag_mem[rd_addr];
      stamp_q <= stamp_mem[rd_addr];
    end
    if (tag_we) begin
      tag_mem[wr_addr] <= search;
    end
    if (stamp_we) begin
      stamp_mem[wr_addr] <= stamp_new;
    end
  end

  // Sequencer, entry bookkeeping and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      valid       <= '0;
      stamp_clock <= '0;
      m_tvalid    <= 1'b0;
      pv          <= 1'b0;
    end else begin
      // The done state reloads the output register itself when it is taken.
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      if (stamp_we) begin
        stamp_clock <= stamp_new;
      end
      if (tag_we) begin
        valid[victim] <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op_r        <= ttc_pkg::op_t'(s_tdata[1:0]);
            search.zoom <= s_tdata[6:2];
            search.col  <= s_tdata[25:7];
            search.row  <= s_tdata[44:26];
            x_lat       <= s_tdata[25:7];
            y_lat       <= s_tdata[44:26];
            lvl         <= '0;
            idx         <= '0;
            pv          <= 1'b0;
            have_inv    <= 1'b0;
            inv_slot    <= '0;
            min_slot    <= '0;
            min_val     <= '1;
            res_hit     <= 1'b0;
            res_slot    <= '0;
            res_evicted <= 1'b0;
            res_level   <= '0;
            res_sub_x   <= '0;
            res_sub_y   <= '0;
            if (ttc_pkg::op_t'(s_tdata[1:0]) == ttc_pkg::OP_NONE) begin
              state <= ST_DONE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          if (issue) begin
            idx <= idx + 1'b1;
          end
          // At the end of a pass no read is in flight, so pv falls here as well.
          pv       <= issue;
          p_idx    <= rd_addr;
          have_inv <= have_inv_next;
          inv_slot <= inv_slot_next;
          min_slot <= min_slot_next;
          min_val  <= min_val_next;

          if (hit_now) begin
            // A matching entry: it is stamped by the memory write above.
            res_hit   <= 1'b1;
            res_slot  <= ttc_pkg::SLOT_W'(p_idx);
            res_level <= lvl;
            res_sub_x <= prod_x[ttc_pkg::SUB_W-1:0];
            res_sub_y <= prod_y[ttc_pkg::SUB_W-1:0];
            state     <= ST_DONE;
          end else if (end_now) begin
            if (op_r == ttc_pkg::OP_INSERT) begin
              res_hit     <= 1'b1;
              res_slot    <= ttc_pkg::SLOT_W'(victim);
              res_evicted <= !have_inv_next;
              state       <= ST_DONE;
            end else if (more_levels) begin
              // Step up one level to the parent tile and scan again.
              lvl         <= lvl + 1'b1;
              search.zoom <= search.zoom - 1'b1;
              search.col  <= search.col >> 1;
              search.row  <= search.row >> 1;
              idx         <= '0;
            end else begin
              state <= ST_DONE;
            end
          end
        end

        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'b0, res_sub_y, res_sub_x, res_level, res_evicted,
                         res_slot, res_hit};
            state    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The stamp clock only ever advances by one.
  a_stamp_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(stamp_clock) |-> (stamp_clock == $past(stamp_clock) + 1'b1))
    else $error("stamp clock jumped");

  // Outside reset an entry, once valid, stays valid.
  a_valid_keep: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((valid & $past(valid)) == $past(valid)))
    else $error("valid entry lost");

  // An eviction is only reported together with a hit.
  a_evict_hit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[5]) |-> m_tdata[0])
    else $error("eviction without hit");

  // A nonzero ancestor level is only reported on a hit.
  a_level_hit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[8:6] != 3'd0)) |-> m_tdata[0])
    else $error("level without hit");

endmodule
